### hdl/tskt_pkg.sv
// shared types, widths and codes for the timestamp sorted keyed table
// no dependencies; used by the compare unit, the top level and the checker
`default_nettype none

package tskt_pkg;

   localparam int CAPACITY_DEF = 32;
   localparam int FUNC_W       = 2;
   localparam int KEY_W        = 32;
   localparam int STAMP_W      = 64;
   localparam int RANK_W       = 6;
   localparam int EV_W         = 4;

   typedef logic [FUNC_W-1:0] func_type;
   typedef logic [EV_W-1:0]   ev_type;

   localparam func_type FUNC_ADD    = 2'd0;
   localparam func_type FUNC_REMOVE = 2'd1;
   localparam func_type FUNC_CLEAR  = 2'd2;
   localparam func_type FUNC_READ   = 2'd3;

   localparam ev_type EV_ADDED     = 4'd0;
   localparam ev_type EV_CHANGED   = 4'd1;
   localparam ev_type EV_UNCHANGED = 4'd2;
   localparam ev_type EV_REMOVED   = 4'd3;
   localparam ev_type EV_NOTFOUND  = 4'd4;
   localparam ev_type EV_FULL      = 4'd5;
   localparam ev_type EV_READOK    = 4'd6;
   localparam ev_type EV_READEND   = 4'd7;
   localparam ev_type EV_CLEARDONE = 4'd8;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic key_eq;
      logic stamp_eq;
      logic keep_before;
   } cmp_type;

endpackage

`default_nettype wire

### hdl/tskt_cmp.sv
// compare unit: key match and signed timestamp order of one stored entry
// depends on tskt_pkg
`default_nettype none

module tskt_cmp (
   input  tskt_pkg::entry_type          entry,
   input  logic [tskt_pkg::KEY_W-1:0]   probe_key,
   input  logic [tskt_pkg::STAMP_W-1:0] probe_stamp,
   output tskt_pkg::cmp_type            result
);

   always_comb begin
      result.key_eq      = (entry.key == probe_key);
      result.stamp_eq    = (entry.stamp == probe_stamp);
      // stored entry stays ahead of the probe when its stamp is equal or larger
      result.keep_before = ($signed(entry.stamp) >= $signed(probe_stamp));
   end

endmodule

`default_nettype wire

### hdl/timestamp_sorted_keyed_table.sv
// top level: sorted keyed table with entry memory and a small sequencer
// depends on tskt_pkg and tskt_cmp
//
// Usage: drive req_func, req_key, req_stamp and req_rank with start high; the
// command is taken at a rising edge where start is high and busy is low. Results
// come out as beats on the rsp_ ports, each valid for one cycle while rsp_valid
// is high, with rsp_last on the final beat of a command. The receiver cannot
// stall, so beats are never held back.
// Entries sit in descending timestamp order in a one-write, one-read memory with
// registered read data; every step moves at most one entry:
//   add / update / remove : a key scan over the stored entries, a shift of the
//                           entries that must move and, for add or update, one
//                           write of the new entry
//   read at rank          : one read of the entry at that rank, none past the end
//   clear                 : one removed beat per cycle for each entry, then done
// The last beat shows in the first cycle with busy low, and a new command may be
// taken at that same edge. Reset empties the table at once (the entry count goes
// to zero; memory contents are not cleared) and drops busy and rsp_valid.
`default_nettype none

module timestamp_sorted_keyed_table #(
   parameter int CAPACITY = tskt_pkg::CAPACITY_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [tskt_pkg::FUNC_W-1:0]         req_func,
   input  logic [tskt_pkg::KEY_W-1:0]          req_key,
   input  logic signed [tskt_pkg::STAMP_W-1:0] req_stamp,
   input  logic [tskt_pkg::RANK_W-1:0]         req_rank,
   output logic                                rsp_valid,
   output logic [tskt_pkg::EV_W-1:0]           rsp_event_res,
   output logic [tskt_pkg::KEY_W-1:0]          rsp_out_key,
   output logic signed [tskt_pkg::STAMP_W-1:0] rsp_out_stamp,
   output logic                                rsp_last
);

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int RANK_W = tskt_pkg::RANK_W;
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAPACITY);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SCAN  = 6'b000010,
      S_SHIFT = 6'b000100,
      S_PUT   = 6'b001000,
      S_CLEAR = 6'b010000,
      S_READ  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   tskt_pkg::func_type             op_ff, op_in;
   logic [tskt_pkg::KEY_W-1:0]     key_ff, key_in;
   logic [tskt_pkg::STAMP_W-1:0]   stamp_ff, stamp_in;
   logic [RANK_W-1:0]              rank_ff, rank_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic [CNT_W-1:0] pidx_ff, pidx_in;
   logic [CNT_W-1:0] fpos_ff, fpos_in;
   logic [CNT_W-1:0] ipos_ff, ipos_in;
   logic             pend_ff, pend_in;
   logic             found_ff, found_in;
   logic             same_ff, same_in;
   logic             up_ff, up_in;
   logic             put_ff, put_in;
   logic [tskt_pkg::STAMP_W-1:0] fstamp_ff, fstamp_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   tskt_pkg::ev_type             rsp_event_ff, rsp_event_in;
   logic [tskt_pkg::KEY_W-1:0]   rsp_key_ff, rsp_key_in;
   logic [tskt_pkg::STAMP_W-1:0] rsp_stamp_ff, rsp_stamp_in;
   logic                         rsp_last_ff, rsp_last_in;

   // entry memory, one write and one registered read per cycle
   tskt_pkg::entry_type mem [CAPACITY];
   tskt_pkg::entry_type rd_data_ff;
   tskt_pkg::entry_type mem_wdata;
   logic                mem_we, mem_re;
   logic [IDX_W-1:0]    mem_waddr, mem_raddr;

   tskt_pkg::cmp_type cmp_res;

   logic [CNT_W-1:0] ptr_inc, ptr_dec, fpos_inc, hi_sel, wpos;
   logic             scan_done;

   tskt_cmp u_cmp (
      .entry       (rd_data_ff),
      .probe_key   (key_ff),
      .probe_stamp (stamp_ff),
      .result      (cmp_res)
   );

   assign ptr_inc   = ptr_ff + CNT_ONE;
   assign ptr_dec   = ptr_ff - CNT_ONE;
   assign fpos_inc  = fpos_ff + CNT_ONE;
   assign hi_sel    = found_ff ? fpos_ff : count_ff;
   assign wpos      = up_ff ? (pidx_ff + CNT_ONE) : (pidx_ff - CNT_ONE);
   assign scan_done = (ptr_ff == count_ff) && !pend_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      stamp_in     = stamp_ff;
      rank_in      = rank_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      left_in      = left_ff;
      pidx_in      = pidx_ff;
      fpos_in      = fpos_ff;
      ipos_in      = ipos_ff;
      pend_in      = 1'b0;
      found_in     = found_ff;
      same_in      = same_ff;
      up_in        = up_ff;
      put_in       = put_ff;
      fstamp_in    = fstamp_ff;
      rsp_valid_in = 1'b0;
      rsp_event_in = rsp_event_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_stamp_in = rsp_stamp_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_raddr    = ptr_ff[IDX_W-1:0];
      mem_waddr    = wpos[IDX_W-1:0];
      mem_wdata    = rd_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_func;
               key_in   = req_key;
               stamp_in = req_stamp;
               rank_in  = req_rank;
               ptr_in   = '0;
               found_in = 1'b0;
               same_in  = 1'b0;
               ipos_in  = '0;
               case (req_func)
                  tskt_pkg::FUNC_ADD:    state_in = S_SCAN;
                  tskt_pkg::FUNC_REMOVE: state_in = S_SCAN;
                  tskt_pkg::FUNC_CLEAR:  state_in = S_CLEAR;
                  default:               state_in = S_READ;
               endcase
            end
         end

         S_SCAN: begin
            if (ptr_ff != count_ff) begin
               mem_re  = 1'b1;
               pend_in = 1'b1;
               pidx_in = ptr_ff;
               ptr_in  = ptr_inc;
            end
            if (pend_ff) begin
               if (cmp_res.key_eq) begin
                  found_in  = 1'b1;
                  same_in   = cmp_res.stamp_eq;
                  fpos_in   = pidx_ff;
                  fstamp_in = rd_data_ff.stamp;
               end else if (cmp_res.keep_before) begin
                  // insert slot counted in the list without the matching key
                  ipos_in = ipos_ff + CNT_ONE;
               end
            end
            if (scan_done) begin
               if (op_ff == tskt_pkg::FUNC_ADD) begin
                  if (found_ff && same_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_event_in = tskt_pkg::EV_UNCHANGED;
                     rsp_key_in   = key_ff;
                     rsp_stamp_in = stamp_ff;
                     rsp_last_in  = 1'b1;
                     state_in     = S_IDLE;
                  end else if (!found_ff && (count_ff == CNT_CAP)) begin
                     rsp_valid_in = 1'b1;
                     rsp_event_in = tskt_pkg::EV_FULL;
                     rsp_key_in   = key_ff;
                     rsp_stamp_in = stamp_ff;
                     rsp_last_in  = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     state_in = S_SHIFT;
                     put_in   = 1'b1;
                     if (found_ff && (ipos_ff > fpos_ff)) begin
                        // entry moves toward older stamps: close up behind it
                        up_in   = 1'b0;
                        ptr_in  = fpos_inc;
                        left_in = ipos_ff - fpos_ff;
                     end else begin
                        // open a gap at the insert slot
                        up_in   = 1'b1;
                        ptr_in  = hi_sel - CNT_ONE;
                        left_in = hi_sel - ipos_ff;
                     end
                  end
               end else begin
                  if (!found_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_event_in = tskt_pkg::EV_NOTFOUND;
                     rsp_key_in   = key_ff;
                     rsp_stamp_in = '0;
                     rsp_last_in  = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     state_in = S_SHIFT;
                     put_in   = 1'b0;
                     up_in    = 1'b0;
                     ptr_in   = fpos_inc;
                     left_in  = count_ff - fpos_inc;
                  end
               end
            end
         end

         S_SHIFT: begin
            if (left_ff != '0) begin
               mem_re  = 1'b1;
               pend_in = 1'b1;
               pidx_in = ptr_ff;
               ptr_in  = up_ff ? ptr_dec : ptr_inc;
               left_in = left_ff - CNT_ONE;
            end
            if (pend_ff) begin
               mem_we = 1'b1;
            end
            if ((left_ff == '0) && !pend_ff) begin
               if (put_ff) begin
                  state_in = S_PUT;
               end else begin
                  count_in     = count_ff - CNT_ONE;
                  rsp_valid_in = 1'b1;
                  rsp_event_in = tskt_pkg::EV_REMOVED;
                  rsp_key_in   = key_ff;
                  rsp_stamp_in = fstamp_ff;
                  rsp_last_in  = 1'b1;
                  state_in     = S_IDLE;
               end
            end
         end

         S_PUT: begin
            mem_we          = 1'b1;
            mem_waddr       = ipos_ff[IDX_W-1:0];
            mem_wdata.key   = key_ff;
            mem_wdata.stamp = stamp_ff;
            if (!found_ff) begin
               count_in = count_ff + CNT_ONE;
            end
            rsp_valid_in = 1'b1;
            rsp_event_in = found_ff ? tskt_pkg::EV_CHANGED : tskt_pkg::EV_ADDED;
            rsp_key_in   = key_ff;
            rsp_stamp_in = stamp_ff;
            rsp_last_in  = 1'b1;
            state_in     = S_IDLE;
         end

         S_CLEAR: begin
            if (ptr_ff != count_ff) begin
               mem_re  = 1'b1;
               pend_in = 1'b1;
               ptr_in  = ptr_inc;
            end
            if (pend_ff) begin
               rsp_valid_in = 1'b1;
               rsp_event_in = tskt_pkg::EV_REMOVED;
               rsp_key_in   = rd_data_ff.key;
               rsp_stamp_in = rd_data_ff.stamp;
               rsp_last_in  = 1'b0;
            end
            if (scan_done) begin
               count_in     = '0;
               rsp_valid_in = 1'b1;
               rsp_event_in = tskt_pkg::EV_CLEARDONE;
               rsp_key_in   = '0;
               rsp_stamp_in = '0;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end

         S_READ: begin
            if (pend_ff) begin
               rsp_valid_in = 1'b1;
               rsp_event_in = tskt_pkg::EV_READOK;
               rsp_key_in   = rd_data_ff.key;
               rsp_stamp_in = rd_data_ff.stamp;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end else if (rank_ff < RANK_W'(count_ff)) begin
               mem_re    = 1'b1;
               mem_raddr = rank_ff[IDX_W-1:0];
               pend_in   = 1'b1;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_event_in = tskt_pkg::EV_READEND;
               rsp_key_in   = '0;
               rsp_stamp_in = '0;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      stamp_ff     <= stamp_in;
      rank_ff      <= rank_in;
      ptr_ff       <= ptr_in;
      left_ff      <= left_in;
      pidx_ff      <= pidx_in;
      fpos_ff      <= fpos_in;
      ipos_ff      <= ipos_in;
      found_ff     <= found_in;
      same_ff      <= same_in;
      up_ff        <= up_in;
      put_ff       <= put_in;
      fstamp_ff    <= fstamp_in;
      rsp_event_ff <= rsp_event_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_stamp_ff <= rsp_stamp_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = rsp_event_ff;
   assign rsp_out_key   = rsp_key_ff;
   assign rsp_out_stamp = rsp_stamp_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

`default_nettype wire

### hdl/tskt_check.sv
// port-level checker for the sorted keyed table, bound to the top level
// depends on tskt_pkg and timestamp_sorted_keyed_table
`default_nettype none

module tskt_check (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic [tskt_pkg::FUNC_W-1:0]         req_func,
   input logic [tskt_pkg::KEY_W-1:0]          req_key,
   input logic signed [tskt_pkg::STAMP_W-1:0] req_stamp,
   input logic [tskt_pkg::RANK_W-1:0]         req_rank,
   input logic                                rsp_valid,
   input logic [tskt_pkg::EV_W-1:0]           rsp_event_res,
   input logic [tskt_pkg::KEY_W-1:0]          rsp_out_key,
   input logic signed [tskt_pkg::STAMP_W-1:0] rsp_out_stamp,
   input logic                                rsp_last
);

   // reset leaves the block idle with no beat on the way
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("beat or busy right after reset");

   // a taken command keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("not busy after command taken");

   // beats before the last come back to back, while busy, and only from clear
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("gap inside a result burst");

   a_mid_removed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy && (rsp_event_res == tskt_pkg::EV_REMOVED))
      else $error("non-final beat is not a busy removed beat");

   // the final beat marks the end of the command
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("final beat while still busy");

endmodule

bind timestamp_sorted_keyed_table tskt_check u_tskt_check (.*);

`default_nettype wire

### test/timestamp_sorted_keyed_table_tb.sv
// self-checking testbench for timestamp_sorted_keyed_table: drives commands and
// mirrors the sorted table to predict every result beat
// depends on tskt_pkg and the timestamp_sorted_keyed_table rtl
`timescale 1ns / 100ps

module timestamp_sorted_keyed_table_tb;

   localparam int CAPACITY      = tskt_pkg::CAPACITY_DEF;
   localparam int FUNC_W        = tskt_pkg::FUNC_W;
   localparam int KEY_W         = tskt_pkg::KEY_W;
   localparam int STAMP_W       = tskt_pkg::STAMP_W;
   localparam int RANK_W        = tskt_pkg::RANK_W;
   localparam int EV_W          = tskt_pkg::EV_W;
   localparam int POOL_SIZE     = 40;
   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 2 * CAPACITY + 8;

   localparam logic signed [STAMP_W-1:0] STAMP_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [STAMP_W-1:0] STAMP_MIN = 64'sh8000_0000_0000_0000;

   typedef struct {
      tskt_pkg::ev_type          ev;
      logic [KEY_W-1:0]          key;
      logic signed [STAMP_W-1:0] stamp;
      logic                      last;
   } table_event_type;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [FUNC_W-1:0]         req_func;
   logic [KEY_W-1:0]          req_key;
   logic signed [STAMP_W-1:0] req_stamp;
   logic [RANK_W-1:0]         req_rank;
   logic                      rsp_valid;
   logic [EV_W-1:0]           rsp_event_res;
   logic [KEY_W-1:0]          rsp_out_key;
   logic signed [STAMP_W-1:0] rsp_out_stamp;
   logic                      rsp_last;

   table_event_type           pending_events[$];
   logic [KEY_W-1:0]          shadow_keys[CAPACITY];
   logic signed [STAMP_W-1:0] shadow_stamps[CAPACITY];
   int                        shadow_count;
   logic [KEY_W-1:0]          key_pool[POOL_SIZE];
   int                        sender_idle_pct;
   int                        errors;
   int                        beats_seen;
   int                        ops_sent[4];
   int                        quiet_cycles = 0;

   timestamp_sorted_keyed_table #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_func(req_func),
      .req_key(req_key),
      .req_stamp(req_stamp),
      .req_rank(req_rank),
      .rsp_valid(rsp_valid),
      .rsp_event_res(rsp_event_res),
      .rsp_out_key(rsp_out_key),
      .rsp_out_stamp(rsp_out_stamp),
      .rsp_last(rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---- table mirror ----

   function automatic void push_event(tskt_pkg::ev_type ev, logic [KEY_W-1:0] k,
                                      logic signed [STAMP_W-1:0] s, logic last);
      table_event_type e;
      e.ev    = ev;
      e.key   = k;
      e.stamp = s;
      e.last  = last;
      pending_events.push_back(e);
   endfunction

   function automatic int find_entry(logic [KEY_W-1:0] k);
      for (int i = 0; i < shadow_count; i++)
         if (shadow_keys[i] == k) return i;
      return -1;
   endfunction

   function automatic void drop_entry(int pos);
      for (int i = pos; i + 1 < shadow_count; i++) begin
         shadow_keys[i]   = shadow_keys[i + 1];
         shadow_stamps[i] = shadow_stamps[i + 1];
      end
      shadow_count--;
   endfunction

   // new entry goes behind every entry with an equal or newer stamp
   function automatic void place_entry(logic [KEY_W-1:0] k,
                                       logic signed [STAMP_W-1:0] s);
      int pos;
      pos = 0;
      while (pos < shadow_count && !(shadow_stamps[pos] < s)) pos++;
      for (int i = shadow_count; i > pos; i--) begin
         shadow_keys[i]   = shadow_keys[i - 1];
         shadow_stamps[i] = shadow_stamps[i - 1];
      end
      shadow_keys[pos]   = k;
      shadow_stamps[pos] = s;
      shadow_count++;
   endfunction

   function automatic void table_step(tskt_pkg::func_type f, logic [KEY_W-1:0] k,
                                      logic signed [STAMP_W-1:0] s, logic [RANK_W-1:0] r);
      int pos;
      logic signed [STAMP_W-1:0] held;
      case (f)
         tskt_pkg::FUNC_ADD: begin
            pos = find_entry(k);
            if (pos >= 0) begin
               if (shadow_stamps[pos] == s) begin
                  push_event(tskt_pkg::EV_UNCHANGED, k, s, 1'b1);
               end else begin
                  drop_entry(pos);
                  place_entry(k, s);
                  push_event(tskt_pkg::EV_CHANGED, k, s, 1'b1);
               end
            end else if (shadow_count >= CAPACITY) begin
               push_event(tskt_pkg::EV_FULL, k, s, 1'b1);
            end else begin
               place_entry(k, s);
               push_event(tskt_pkg::EV_ADDED, k, s, 1'b1);
            end
         end
         tskt_pkg::FUNC_REMOVE: begin
            pos = find_entry(k);
            if (pos < 0) begin
               push_event(tskt_pkg::EV_NOTFOUND, k, '0, 1'b1);
            end else begin
               held = shadow_stamps[pos];
               drop_entry(pos);
               push_event(tskt_pkg::EV_REMOVED, k, held, 1'b1);
            end
         end
         tskt_pkg::FUNC_CLEAR: begin
            for (int i = 0; i < shadow_count; i++)
               push_event(tskt_pkg::EV_REMOVED, shadow_keys[i], shadow_stamps[i], 1'b0);
            push_event(tskt_pkg::EV_CLEARDONE, '0, '0, 1'b1);
            shadow_count = 0;
         end
         default: begin
            if (int'(r) < shadow_count)
               push_event(tskt_pkg::EV_READOK, shadow_keys[r], shadow_stamps[r], 1'b1);
            else
               push_event(tskt_pkg::EV_READEND, '0, '0, 1'b1);
         end
      endcase
   endfunction

   // ---- stimulus helpers ----

   function automatic logic [KEY_W-1:0] pick_key();
      int roll;
      roll = $urandom_range(99);
      if (roll < 20 && shadow_count > 0) return shadow_keys[$urandom_range(shadow_count - 1)];
      if (roll < 90) return key_pool[$urandom_range(POOL_SIZE - 1)];
      return $urandom;
   endfunction

   function automatic logic signed [STAMP_W-1:0] pick_stamp();
      int roll;
      int near_zero;
      roll = $urandom_range(99);
      if (roll < 15 && shadow_count > 0)
         return shadow_stamps[$urandom_range(shadow_count - 1)];
      if (roll < 40) begin
         // narrow range so equal stamps and ties show up often
         near_zero = int'($urandom_range(8)) - 4;
         return STAMP_W'(near_zero);
      end
      if (roll < 50) begin
         case ($urandom_range(3))
            0: return STAMP_MIN;
            1: return STAMP_MAX;
            2: return '0;
            default: return '1;
         endcase
      end
      return {$urandom, $urandom};
   endfunction

   function automatic logic [RANK_W-1:0] pick_rank();
      if ($urandom_range(1) && shadow_count > 0) return RANK_W'($urandom_range(shadow_count));
      return RANK_W'($urandom_range(63));
   endfunction

   task automatic send_command(input tskt_pkg::func_type f, input logic [KEY_W-1:0] k,
                               input logic signed [STAMP_W-1:0] s,
                               input logic [RANK_W-1:0] r);
      @(negedge clock);
      start = 1'b0;
      // hold off while busy, then leave random gaps between commands
      while (busy || ($urandom_range(99) < sender_idle_pct)) @(negedge clock);
      req_func  = f;
      req_key   = k;
      req_stamp = s;
      req_rank  = r;
      start     = 1'b1;
      // busy was low at the falling edge, so this edge takes the command
      @(posedge clock);
      table_step(f, k, s, r);
      ops_sent[f]++;
   endtask

   task automatic drain_events(input int settle);
      @(negedge clock);
      start = 1'b0;
      while (pending_events.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   // ---- tests ----

   task automatic test_empty_table();
      send_command(tskt_pkg::FUNC_CLEAR, 32'hFFFF_FFFF, STAMP_MAX, 6'd63);
      send_command(tskt_pkg::FUNC_READ, 32'h0, '1, 6'd0);
      send_command(tskt_pkg::FUNC_REMOVE, 32'h1234_5678, STAMP_MIN, 6'd63);
   endtask

   task automatic test_ordering_and_updates();
      send_command(tskt_pkg::FUNC_ADD, 32'h0, STAMP_MAX, 6'd63);
      send_command(tskt_pkg::FUNC_ADD, 32'hFFFF_FFFF, STAMP_MIN, 6'd0);
      send_command(tskt_pkg::FUNC_ADD, 32'h5A5A_5A5A, '0, 6'd21);
      // equal stamp lands behind the older entry
      send_command(tskt_pkg::FUNC_ADD, 32'hA5A5_A5A5, '0, 6'd42);
      send_command(tskt_pkg::FUNC_ADD, 32'h1, '1, 6'd0);
      send_command(tskt_pkg::FUNC_ADD, 32'h0, STAMP_MAX, 6'd0);
      send_command(tskt_pkg::FUNC_ADD, 32'hFFFF_FFFF, STAMP_MAX, 6'd0);
      send_command(tskt_pkg::FUNC_ADD, 32'h0, STAMP_MIN, 6'd0);
      send_command(tskt_pkg::FUNC_READ, 32'hFFFF_FFFF, STAMP_MAX, 6'd0);
      send_command(tskt_pkg::FUNC_READ, 32'h0, '0, 6'd4);
      send_command(tskt_pkg::FUNC_READ, 32'h0, '0, 6'd5);
      send_command(tskt_pkg::FUNC_READ, 32'hFFFF_FFFF, STAMP_MIN, 6'd63);
      send_command(tskt_pkg::FUNC_REMOVE, 32'h5A5A_5A5A, '1, 6'd0);
      send_command(tskt_pkg::FUNC_REMOVE, 32'h5A5A_5A5A, '0, 6'd0);
      send_command(tskt_pkg::FUNC_CLEAR, 32'h0, '0, 6'd0);
      send_command(tskt_pkg::FUNC_READ, 32'h0, '0, 6'd0);
   endtask

   task automatic test_fill_to_capacity();
      logic [KEY_W-1:0] victim;
      for (int i = 0; i < CAPACITY + 3; i++)
         send_command(tskt_pkg::FUNC_ADD, $urandom, pick_stamp(), pick_rank());
      // moving an entry inside a full table is still allowed
      send_command(tskt_pkg::FUNC_ADD, shadow_keys[CAPACITY - 1], STAMP_MAX, pick_rank());
      send_command(tskt_pkg::FUNC_READ, $urandom, pick_stamp(), RANK_W'(CAPACITY - 1));
      send_command(tskt_pkg::FUNC_READ, $urandom, pick_stamp(), RANK_W'(CAPACITY));
      victim = shadow_keys[$urandom_range(CAPACITY - 1)];
      send_command(tskt_pkg::FUNC_REMOVE, victim, pick_stamp(), pick_rank());
      send_command(tskt_pkg::FUNC_ADD, $urandom, pick_stamp(), pick_rank());
      send_command(tskt_pkg::FUNC_ADD, $urandom, pick_stamp(), pick_rank());
      send_command(tskt_pkg::FUNC_CLEAR, $urandom, pick_stamp(), pick_rank());
   endtask

   task automatic test_random_traffic(input int items, input int idle_pct);
      int roll;
      sender_idle_pct = idle_pct;
      for (int i = 0; i < items; i++) begin
         roll = $urandom_range(99);
         if (roll < 55)
            send_command(tskt_pkg::FUNC_ADD, pick_key(), pick_stamp(), pick_rank());
         else if (roll < 75)
            send_command(tskt_pkg::FUNC_REMOVE, pick_key(), pick_stamp(), pick_rank());
         else if (roll < 96)
            send_command(tskt_pkg::FUNC_READ, pick_key(), pick_stamp(), pick_rank());
         else
            send_command(tskt_pkg::FUNC_CLEAR, pick_key(), pick_stamp(), pick_rank());
      end
   endtask

   // ---- result checking ----

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : check_beats
      table_event_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_events.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, expected none, got ev %0d key %h stamp %h last %b",
                     $time, rsp_event_res, rsp_out_key, rsp_out_stamp, rsp_last);
         end else begin
            want = pending_events.pop_front();
            check_field("event", 64'(want.ev), 64'(rsp_event_res));
            check_field("key", 64'(want.key), 64'(rsp_out_key));
            check_field("stamp", want.stamp, rsp_out_stamp);
            check_field("last", 64'(want.last), 64'(rsp_last));
            beats_seen++;
         end
      end
   end

   // ends the run if neither a command nor a beat moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d beats outstanding",
                  $time, quiet_cycles, pending_events.size());
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_func        = tskt_pkg::FUNC_ADD;
      req_key         = '0;
      req_stamp       = '0;
      req_rank        = '0;
      sender_idle_pct = 0;
      errors          = 0;
      beats_seen      = 0;
      shadow_count    = 0;
      foreach (ops_sent[i]) ops_sent[i] = 0;
      foreach (key_pool[i]) key_pool[i] = $urandom;
      key_pool[0] = '0;
      key_pool[1] = '1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_table();
      test_ordering_and_updates();
      test_fill_to_capacity();
      test_random_traffic(140, 0);
      drain_events(2);
      test_random_traffic(140, 82);
      drain_events(2);
      test_random_traffic(140, 37);
      drain_events(SETTLE_CYCLES);

      $display("covered %0d adds, %0d removes, %0d clears, %0d reads; %0d beats checked",
               ops_sent[tskt_pkg::FUNC_ADD], ops_sent[tskt_pkg::FUNC_REMOVE],
               ops_sent[tskt_pkg::FUNC_CLEAR], ops_sent[tskt_pkg::FUNC_READ], beats_seen);
      $display("incl. full table, ties, extreme stamps, reads past the end, gaps 0/82/37 pct");
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

### files.f
hdl/tskt_pkg.sv
hdl/tskt_cmp.sv
hdl/timestamp_sorted_keyed_table.sv
hdl/tskt_check.sv
test/timestamp_sorted_keyed_table_tb.sv
